/* hw/rtl/erm_pkg.sv */
// ----------------------------------------------------------------------------
// erm_pkg
// Shared constants, state encoding and controller/datapath interface types
// for the extent range map read block.
// ----------------------------------------------------------------------------
package erm_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int MAX_SEGS    = 16;
  localparam int BLK_W       = 48;
  localparam int LEN_BITS    = 32;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int N_W         = $clog2(MAX_ENTRIES + 1);
  localparam int SEG_W       = $clog2(MAX_SEGS + 1);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_EXT_RD0,
    ST_EXT_LD0,
    ST_EXT_ADJ,
    ST_EXT_RD,
    ST_EXT_DIST,
    ST_EXT_EMIT,
    ST_TAIL,
    ST_TAIL_EMIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_wr;
    logic query_start;
    logic addr_scan;
    logic scan_step;
    logic ext_load;
    logic ext_adjust;
    logic ext_dist;
    logic ext_emit;
    logic tail_prep;
    logic tail_emit;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op_query;
    logic query_room_zero;
    logic query_n_zero;
    logic scan_eq;
    logic scan_lt;
    logic scan_first;
    logic scan_last;
    logic ext_more;
    logic tail_ok;
  } ctrl_status_t;

endpackage

/* hw/rtl/erm_ctrl.sv */
// ----------------------------------------------------------------------------
// erm_ctrl
// Sequencer for loads and range queries: table scan, extent segments,
// tail hole and final result.
// ----------------------------------------------------------------------------
module erm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  erm_pkg::ctrl_status_t status,
  output erm_pkg::ctrl_cmd_t    cmd,
  output logic                  busy
);

  erm_pkg::state_t state;
  erm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= erm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      erm_pkg::ST_IDLE: begin
        if (start && status.op_query) begin
          if (status.query_room_zero) begin
            state_next = erm_pkg::ST_FINISH;
          end else if (status.query_n_zero) begin
            state_next = erm_pkg::ST_TAIL;
          end else begin
            state_next = erm_pkg::ST_SCAN_RD;
          end
        end
      end
      erm_pkg::ST_SCAN_RD: state_next = erm_pkg::ST_SCAN_CMP;
      erm_pkg::ST_SCAN_CMP: begin
        if (status.scan_eq) begin
          state_next = status.scan_last ? erm_pkg::ST_TAIL : erm_pkg::ST_EXT_RD0;
        end else if (status.scan_lt) begin
          state_next = status.scan_first ? erm_pkg::ST_TAIL : erm_pkg::ST_EXT_RD0;
        end else if (status.scan_last) begin
          state_next = erm_pkg::ST_TAIL;
        end else begin
          state_next = erm_pkg::ST_SCAN_RD;
        end
      end
      erm_pkg::ST_EXT_RD0:  state_next = erm_pkg::ST_EXT_LD0;
      erm_pkg::ST_EXT_LD0:  state_next = erm_pkg::ST_EXT_ADJ;
      erm_pkg::ST_EXT_ADJ:  state_next = erm_pkg::ST_EXT_DIST;
      erm_pkg::ST_EXT_RD:   state_next = erm_pkg::ST_EXT_DIST;
      erm_pkg::ST_EXT_DIST: state_next = erm_pkg::ST_EXT_EMIT;
      erm_pkg::ST_EXT_EMIT: begin
        state_next = status.ext_more ? erm_pkg::ST_EXT_RD : erm_pkg::ST_TAIL;
      end
      erm_pkg::ST_TAIL:      state_next = erm_pkg::ST_TAIL_EMIT;
      erm_pkg::ST_TAIL_EMIT: state_next = erm_pkg::ST_FINISH;
      erm_pkg::ST_FINISH:    state_next = erm_pkg::ST_IDLE;
      default:               state_next = erm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      erm_pkg::ST_IDLE: begin
        busy            = 1'b0;
        cmd.load_wr     = start && !status.op_query;
        cmd.query_start = start && status.op_query;
      end
      erm_pkg::ST_SCAN_RD:   cmd.addr_scan  = 1'b1;
      erm_pkg::ST_SCAN_CMP:  cmd.scan_step  = 1'b1;
      erm_pkg::ST_EXT_RD0:   cmd.addr_scan  = 1'b0;
      erm_pkg::ST_EXT_LD0:   cmd.ext_load   = 1'b1;
      erm_pkg::ST_EXT_ADJ:   cmd.ext_adjust = 1'b1;
      erm_pkg::ST_EXT_RD:    cmd.addr_scan  = 1'b0;
      erm_pkg::ST_EXT_DIST:  cmd.ext_dist   = 1'b1;
      erm_pkg::ST_EXT_EMIT:  cmd.ext_emit   = 1'b1;
      erm_pkg::ST_TAIL:      cmd.tail_prep  = 1'b1;
      erm_pkg::ST_TAIL_EMIT: cmd.tail_emit  = 1'b1;
      erm_pkg::ST_FINISH:    cmd.finish     = 1'b1;
      default:               cmd            = '0;
    endcase
  end

endmodule

/* hw/rtl/erm_datapath.sv */
// ----------------------------------------------------------------------------
// erm_datapath
// Extent table memories, query registers, segment arithmetic, pending
// segment and registered result word.
// ----------------------------------------------------------------------------
module erm_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  erm_pkg::ctrl_cmd_t              cmd,
  output erm_pkg::ctrl_status_t           status,
  input  logic                            operation,
  input  logic [7:0]                      entry_index,
  input  logic [erm_pkg::BLK_W-1:0]       entry_logical,
  input  logic [erm_pkg::BLK_W-1:0]       entry_physical,
  input  logic [8:0]                      entries_in_use,
  input  logic [erm_pkg::BLK_W-1:0]       range_start,
  input  logic [erm_pkg::LEN_BITS-1:0]    range_len,
  input  logic [erm_pkg::BLK_W-1:0]       key_end,
  input  logic [4:0]                      seg_room,
  output logic                            seg_valid,
  output logic [erm_pkg::BLK_W-1:0]       seg_block,
  output logic [erm_pkg::LEN_BITS-1:0]    seg_count,
  output logic                            seg_hole,
  output logic                            no_segment,
  output logic [erm_pkg::BLK_W-1:0]       next_start,
  output logic [erm_pkg::LEN_BITS-1:0]    remaining_len,
  output logic                            last
);

  logic [erm_pkg::BLK_W-1:0]     mem_lg [erm_pkg::MAX_ENTRIES];
  logic [erm_pkg::BLK_W-1:0]     mem_ph [erm_pkg::MAX_ENTRIES];
  logic [erm_pkg::BLK_W-1:0]     rd_lg;
  logic [erm_pkg::BLK_W-1:0]     rd_ph;
  logic [erm_pkg::IDX_W-1:0]     addr;
  logic                          slot_ok;

  logic [erm_pkg::BLK_W-1:0]     q_start;
  logic [erm_pkg::LEN_BITS-1:0]  q_len;
  logic [erm_pkg::BLK_W-1:0]     q_limit;
  logic [erm_pkg::N_W-1:0]       q_n;
  logic [erm_pkg::SEG_W-1:0]     q_room;
  logic [erm_pkg::N_W-1:0]       i;
  logic [erm_pkg::N_W-1:0]       ptr;
  logic [erm_pkg::SEG_W-1:0]     segs;
  logic [erm_pkg::BLK_W-1:0]     phys;
  logic [erm_pkg::BLK_W-1:0]     off;
  logic [erm_pkg::BLK_W-1:0]     gap_len;
  logic [erm_pkg::BLK_W-1:0]     nphys;
  logic [erm_pkg::BLK_W-1:0]     tail_dist;
  logic                          tail_ok;

  logic                          pend_valid;
  logic [erm_pkg::BLK_W-1:0]     pend_block;
  logic [erm_pkg::LEN_BITS-1:0]  pend_count;
  logic                          pend_hole;
  logic [erm_pkg::BLK_W-1:0]     pend_next;
  logic [erm_pkg::LEN_BITS-1:0]  pend_rem;

  logic                          do_emit;
  logic [erm_pkg::BLK_W-1:0]     dsel;
  logic [erm_pkg::LEN_BITS-1:0]  cnt;
  logic [erm_pkg::BLK_W-1:0]     e_block;
  logic                          e_hole;

  assign slot_ok = 32'(entry_index) < 32'(erm_pkg::MAX_ENTRIES);
  assign addr    = cmd.addr_scan ? i[erm_pkg::IDX_W-1:0] : ptr[erm_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_wr && slot_ok) begin
      mem_lg[erm_pkg::IDX_W'(entry_index)] <= entry_logical;
      mem_ph[erm_pkg::IDX_W'(entry_index)] <= entry_physical;
    end
    rd_lg <= mem_lg[addr];
    rd_ph <= mem_ph[addr];
  end

  always_comb begin
    status.op_query        = operation;
    status.query_room_zero = seg_room == 5'd0;
    status.query_n_zero    = entries_in_use == 9'd0;
    status.scan_eq         = q_start == rd_lg;
    status.scan_lt         = q_start < rd_lg;
    status.scan_first      = i == '0;
    status.scan_last       = ({1'b0, i} + 1'b1) == {1'b0, q_n};
    status.ext_more        = ({16'd0, q_len} > gap_len)
                             && (({1'b0, segs} + 1'b1) < {1'b0, q_room})
                             && (({1'b0, ptr} + 1'b1) < {1'b0, q_n});
    status.tail_ok         = tail_ok;
  end

  // shared segment arithmetic
  assign do_emit = cmd.ext_emit || (cmd.tail_emit && tail_ok);
  assign dsel    = cmd.tail_emit ? tail_dist : gap_len;
  assign cnt     = ({16'd0, q_len} < dsel) ? q_len : dsel[erm_pkg::LEN_BITS-1:0];
  assign e_block = cmd.tail_emit ? '0 : phys;
  assign e_hole  = cmd.tail_emit ? 1'b1 : (phys == '0);

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      q_start <= range_start;
      q_len   <= range_len;
      q_limit <= key_end;
      if (32'(entries_in_use) > 32'(erm_pkg::MAX_ENTRIES)) begin
        q_n <= erm_pkg::N_W'(erm_pkg::MAX_ENTRIES);
      end else begin
        q_n <= erm_pkg::N_W'(entries_in_use);
      end
      if (32'(seg_room) > 32'(erm_pkg::MAX_SEGS)) begin
        q_room <= erm_pkg::SEG_W'(erm_pkg::MAX_SEGS);
      end else begin
        q_room <= erm_pkg::SEG_W'(seg_room);
      end
      i    <= '0;
      segs <= '0;
    end
    if (cmd.scan_step) begin
      i   <= i + 1'b1;
      ptr <= status.scan_eq ? i : i - 1'b1;
    end
    if (cmd.ext_load) begin
      phys <= rd_ph;
      off  <= q_start - rd_lg;
      ptr  <= ptr + 1'b1;
    end
    if (cmd.ext_adjust && (phys != '0)) begin
      phys <= phys + off;
    end
    if (cmd.ext_dist) begin
      gap_len <= rd_lg - q_start;
      nphys   <= rd_ph;
    end
    if (cmd.ext_emit) begin
      phys <= nphys;
      ptr  <= ptr + 1'b1;
    end
    if (cmd.tail_prep) begin
      tail_dist <= q_limit - q_start;
      tail_ok   <= (q_start < q_limit) && (q_len != '0) && (segs < q_room);
    end
    if (do_emit) begin
      q_start    <= q_start + erm_pkg::BLK_W'(cnt);
      q_len      <= q_len - cnt;
      segs       <= segs + 1'b1;
      pend_block <= e_block;
      pend_count <= cnt;
      pend_hole  <= e_hole;
      pend_next  <= q_start + erm_pkg::BLK_W'(cnt);
      pend_rem   <= q_len - cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.finish || cmd.query_start) begin
      pend_valid <= 1'b0;
    end else if (do_emit) begin
      pend_valid <= 1'b1;
    end
  end

  // result word: hold the previous segment until the next one or the end
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else begin
      seg_valid <= (do_emit && pend_valid) || cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if ((do_emit && pend_valid) || (cmd.finish && pend_valid)) begin
      seg_block     <= pend_block;
      seg_count     <= pend_count;
      seg_hole      <= pend_hole;
      no_segment    <= 1'b0;
      next_start    <= pend_next;
      remaining_len <= pend_rem;
      last          <= cmd.finish;
    end else if (cmd.finish) begin
      seg_block     <= '0;
      seg_count     <= '0;
      seg_hole      <= 1'b0;
      no_segment    <= 1'b1;
      next_start    <= q_start;
      remaining_len <= q_len;
      last          <= 1'b1;
    end
  end

endmodule

/* hw/rtl/extent_range_map_read.sv */
// ----------------------------------------------------------------------------
// extent_range_map_read
// Extent table lookup: loads sorted extent entries and answers logical
// range queries with physical segments and a trailing hole.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A load writes one
// table entry and gives no result. A query scans the table from entry 0
// through the one port of the extent memory, reading and comparing each
// entry up to the match, then opens the first extent (read, load, adjust),
// makes each extent segment by reading the next entry, measuring the
// distance and emitting, then prepares the tail hole, emits it if it is
// due, and delivers the final word; a query with no room goes straight to
// the final word. Each result word is shown for exactly one cycle with
// seg_valid high and cannot be held off; last marks the final word of a
// query, and a query with no segment gives one word with no_segment set.
// Entries never loaded since reset read as unknown data.
module extent_range_map_read (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation,
  input  logic [7:0]                    entry_index,
  input  logic [erm_pkg::BLK_W-1:0]     entry_logical,
  input  logic [erm_pkg::BLK_W-1:0]     entry_physical,
  input  logic [8:0]                    entries_in_use,
  input  logic [erm_pkg::BLK_W-1:0]     range_start,
  input  logic [erm_pkg::LEN_BITS-1:0]  range_len,
  input  logic [erm_pkg::BLK_W-1:0]     key_end,
  input  logic [4:0]                    seg_room,
  output logic                          seg_valid,
  output logic [erm_pkg::BLK_W-1:0]     seg_block,
  output logic [erm_pkg::LEN_BITS-1:0]  seg_count,
  output logic                          seg_hole,
  output logic                          no_segment,
  output logic [erm_pkg::BLK_W-1:0]     next_start,
  output logic [erm_pkg::LEN_BITS-1:0]  remaining_len,
  output logic                          last
);

  erm_pkg::ctrl_cmd_t    cmd;
  erm_pkg::ctrl_status_t status;

  erm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  erm_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .operation      (operation),
    .entry_index    (entry_index),
    .entry_logical  (entry_logical),
    .entry_physical (entry_physical),
    .entries_in_use (entries_in_use),
    .range_start    (range_start),
    .range_len      (range_len),
    .key_end        (key_end),
    .seg_room       (seg_room),
    .seg_valid      (seg_valid),
    .seg_block      (seg_block),
    .seg_count      (seg_count),
    .seg_hole       (seg_hole),
    .no_segment     (no_segment),
    .next_start     (next_start),
    .remaining_len  (remaining_len),
    .last           (last)
  );

endmodule

/* hw/rtl/erm_checker.sv */
// ----------------------------------------------------------------------------
// erm_checker
// Port-level checks on result words and command acceptance.
// ----------------------------------------------------------------------------
module erm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          operation,
  input logic                          seg_valid,
  input logic [erm_pkg::BLK_W-1:0]     seg_block,
  input logic [erm_pkg::LEN_BITS-1:0]  seg_count,
  input logic                          seg_hole,
  input logic                          no_segment,
  input logic                          last
);

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    (seg_valid && !last) |-> busy)
    else $error("query idle before its last word");

  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    (seg_valid && no_segment) |-> (last && !seg_hole && seg_block == '0 && seg_count == '0))
    else $error("malformed empty result");

  a_hole_block: assert property (@(posedge clk) disable iff (rst)
    (seg_valid && seg_hole) |-> (seg_block == '0))
    else $error("hole segment with nonzero block");

  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation == erm_pkg::OP_LOAD)) |=> (!busy && !seg_valid))
    else $error("load caused activity");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation == erm_pkg::OP_QUERY)) |=> busy)
    else $error("query not started");

endmodule

bind extent_range_map_read erm_checker u_erm_checker (.*);
